FILE: design/ffsa_pkg.sv
// Package with shared constants, codes and types of the first-free slot allocator.
`default_nettype none

package ffsa_pkg;

    localparam int MAX_SLOTS_DEF  = 64;
    localparam int OWNER_BITS_DEF = 16;
    localparam int MODE_W         = 2;
    localparam int OWNER_ID_W     = 16;
    localparam int SEAT_W         = 7;
    localparam int COUNT_W        = 7;
    localparam int CAP_RESET      = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_QUERY   = 2'd2
    } mode_t;

    typedef struct packed {
        logic               alloc;
        logic               release_hit;
        logic               wipe;
        logic [SEAT_W-1:0]  seat;
        logic [COUNT_W-1:0] cap;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: design/ffsa_if.sv
// Handshake interfaces for the request, result and capacity write channels.
`default_nettype none

interface ffsa_req_if;
    logic                            valid;
    logic                            ready;
    logic [ffsa_pkg::MODE_W-1:0]     mode;
    logic [ffsa_pkg::OWNER_ID_W-1:0] owner_id;
    logic [ffsa_pkg::SEAT_W-1:0]     seat_number;

    modport source (output valid, output mode, output owner_id, output seat_number,
                    input ready);
    modport sink (input valid, input mode, input owner_id, input seat_number,
                  output ready);
endinterface

interface ffsa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [ffsa_pkg::SEAT_W-1:0]     slot_granted;
    logic [ffsa_pkg::OWNER_ID_W-1:0] owner_out;
    logic [ffsa_pkg::COUNT_W-1:0]    occupied_count;
    logic [ffsa_pkg::COUNT_W-1:0]    free_count;

    modport source (output valid, output status, output slot_granted, output owner_out,
                    output occupied_count, output free_count, input ready);
    modport sink (input valid, input status, input slot_granted, input owner_out,
                  input occupied_count, input free_count, output ready);
endinterface

interface ffsa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ffsa_pkg::COUNT_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

FILE: design/ffsa_cell.sv
// One slot cell: holds an owner tag and passes search, grant and read data to its neighbor.
`default_nettype none

module ffsa_cell #(
    parameter int INDEX      = 0,
    parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  ffsa_pkg::cell_cmd_t        cmd,
    input  wire  [OWNER_BITS-1:0]            new_owner,
    input  wire                              taken_in,
    output logic                             taken_out,
    input  wire  [ffsa_pkg::SEAT_W-1:0]      grant_in,
    output logic [ffsa_pkg::SEAT_W-1:0]      grant_out,
    input  wire  [OWNER_BITS-1:0]            rd_in,
    output logic [OWNER_BITS-1:0]            rd_out,
    input  wire                              occ_in,
    output logic                             occ_out
);

    logic                  occ_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic                  in_range;
    logic                  hit;
    logic                  avail;
    logic                  grant;

    assign in_range = ({{(32-ffsa_pkg::COUNT_W){1'b0}}, cmd.cap} > 32'(INDEX));
    assign hit      = ({{(32-ffsa_pkg::SEAT_W){1'b0}}, cmd.seat} == 32'(INDEX + 1));
    assign avail    = in_range && !occ_reg;
    assign grant    = cmd.alloc && avail && !taken_in;

    assign taken_out = taken_in || avail;
    assign grant_out = grant_in | (grant ? ffsa_pkg::SEAT_W'(INDEX + 1) : '0);
    assign rd_out    = rd_in | ((hit && occ_reg) ? owner_reg : '0);
    assign occ_out   = occ_in || (hit && occ_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (cmd.wipe)
        begin
            occ_reg <= 1'b0;
        end
        else if (grant)
        begin
            occ_reg <= 1'b1;
        end
        else if (cmd.release_hit && hit)
        begin
            occ_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grant)
        begin
            owner_reg <= new_owner;
        end
    end

endmodule

`default_nettype wire

FILE: design/first_free_slot_allocator.sv
// Top level of the first-free slot allocator: control, counters and the row of slot cells.
// The request channel carries mode, owner_id and seat_number; each transfer yields exactly
// one transfer on the result channel with status, slot_granted, owner_out and both counts.
// A request is registered in the execute stage and executed against the row of cells, where
// the lowest free slot is found by a carry that ripples from cell to cell and the selected
// slot's owner is collected along the same row. The result is registered in the output
// register, and a new request is taken only after the previous one has been executed.
// The result sits in an output register; while the receiver stalls, one more request is
// taken and waits in the execute stage until the output register frees up.
// The capacity channel writes the slot count (0 is taken as 1, values above MAX_SLOTS as
// MAX_SLOTS) and clears every slot at once; it is ready only while no request is in flight.
// Reset frees every slot, sets the occupied count to zero and the capacity to 64 (or MAX_SLOTS if smaller).
`default_nettype none

module first_free_slot_allocator #(
    parameter int MAX_SLOTS  = ffsa_pkg::MAX_SLOTS_DEF,
    parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
    input wire          clk,
    input wire          rst_n,
    ffsa_req_if.sink    item,
    ffsa_rsp_if.source  result,
    ffsa_cfg_if.sink    cfg
);

    localparam int CW = ffsa_pkg::COUNT_W;
    localparam int SW = ffsa_pkg::SEAT_W;

    logic                  busy_reg;
    logic                  out_valid_reg;
    logic [CW-1:0]         cap_reg;
    logic [CW-1:0]         used_reg;
    logic [CW-1:0]         used_next;
    logic [1:0]            mode_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [SW-1:0]         seat_reg;

    logic                  status_reg;
    logic [SW-1:0]         granted_reg;
    logic [ffsa_pkg::OWNER_ID_W-1:0] owner_out_reg;
    logic [CW-1:0]         occ_count_reg;
    logic [CW-1:0]         free_count_reg;

    logic                  status_next;
    logic [SW-1:0]         granted_next;
    logic [OWNER_BITS-1:0] owner_out_next;

    logic                  req_fire;
    logic                  cfg_fire;
    logic                  exec;
    logic                  seat_ok;
    logic                  alloc_ok;
    logic [CW-1:0]         cap_clamped;
    logic [OWNER_BITS-1:0] owner_in;
    ffsa_pkg::cell_cmd_t   cmd;

    logic                  taken [0:MAX_SLOTS];
    logic [SW-1:0]         gnt   [0:MAX_SLOTS];
    logic [OWNER_BITS-1:0] rd    [0:MAX_SLOTS];
    logic                  occ   [0:MAX_SLOTS];

    assign item.ready = !busy_reg;
    assign cfg.ready  = !busy_reg && !out_valid_reg;
    assign req_fire   = item.valid && item.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign exec       = busy_reg && (!out_valid_reg || result.ready);

    assign owner_in = OWNER_BITS'(item.owner_id);

    always_comb
    begin
        if (cfg.capacity == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if ({{(32-CW){1'b0}}, cfg.capacity} > 32'(MAX_SLOTS))
        begin
            cap_clamped = CW'(MAX_SLOTS);
        end
        else
        begin
            cap_clamped = cfg.capacity;
        end
    end

    assign seat_ok  = (seat_reg != '0) && ({1'b0, seat_reg} <= {1'b0, cap_reg});
    assign alloc_ok = (owner_reg != '0) && (used_reg < cap_reg);

    always_comb
    begin
        cmd.alloc       = exec && (mode_reg == ffsa_pkg::MODE_ALLOC) && alloc_ok;
        cmd.release_hit = exec && (mode_reg == ffsa_pkg::MODE_RELEASE) && seat_ok && occ[MAX_SLOTS];
        cmd.wipe        = cfg_fire;
        cmd.seat        = seat_reg;
        cmd.cap         = cap_reg;
    end

    assign taken[0] = 1'b0;
    assign gnt[0]   = '0;
    assign rd[0]    = '0;
    assign occ[0]   = 1'b0;

    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        ffsa_cell #(
            .INDEX      (i),
            .OWNER_BITS (OWNER_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .new_owner (owner_reg),
            .taken_in  (taken[i]),
            .taken_out (taken[i+1]),
            .grant_in  (gnt[i]),
            .grant_out (gnt[i+1]),
            .rd_in     (rd[i]),
            .rd_out    (rd[i+1]),
            .occ_in    (occ[i]),
            .occ_out   (occ[i+1])
        );
    end

    always_comb
    begin
        status_next    = 1'b1;
        granted_next   = '0;
        owner_out_next = '0;
        used_next      = used_reg;
        unique case (mode_reg)
            ffsa_pkg::MODE_ALLOC:
            begin
                if (alloc_ok)
                begin
                    status_next  = 1'b0;
                    granted_next = gnt[MAX_SLOTS];
                    used_next    = used_reg + CW'(1);
                end
            end
            ffsa_pkg::MODE_RELEASE:
            begin
                if (seat_ok && occ[MAX_SLOTS])
                begin
                    status_next    = 1'b0;
                    owner_out_next = rd[MAX_SLOTS];
                    used_next      = used_reg - CW'(1);
                end
            end
            ffsa_pkg::MODE_QUERY:
            begin
                if (seat_ok)
                begin
                    status_next    = 1'b0;
                    owner_out_next = rd[MAX_SLOTS];
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CW'(ffsa_pkg::CAP_RESET > MAX_SLOTS ? MAX_SLOTS
                                                               : ffsa_pkg::CAP_RESET);
            used_reg      <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                cap_reg  <= cap_clamped;
                used_reg <= '0;
            end
            if (exec)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                used_reg      <= used_next;
            end
            else
            begin
                if (req_fire)
                begin
                    busy_reg <= 1'b1;
                end
                if (result.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg  <= item.mode;
            owner_reg <= owner_in;
            seat_reg  <= item.seat_number;
        end
        if (exec)
        begin
            status_reg     <= status_next;
            granted_reg    <= granted_next;
            owner_out_reg  <= ffsa_pkg::OWNER_ID_W'(owner_out_next);
            occ_count_reg  <= used_next;
            free_count_reg <= cap_reg - used_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.slot_granted   = granted_reg;
    assign result.owner_out      = owner_out_reg;
    assign result.occupied_count = occ_count_reg;
    assign result.free_count     = free_count_reg;

`ifndef SYNTHESIS
    a_used_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= cap_reg)
        else $error("occupied count exceeds capacity");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (used_reg == '0))
        else $error("capacity write did not clear the table");

    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.slot_granted != '0)) |->
            (!result.status && (result.slot_granted <= cap_reg)))
        else $error("granted slot outside capacity");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (({1'b0, result.occupied_count} + {1'b0, result.free_count}) == {1'b0, cap_reg}))
        else $error("occupied and free counts do not add up to capacity");
`endif

endmodule

`default_nettype wire
